### design/sobel_pkg.sv
// Package for the RGB Sobel edge magnitude block.
// Payload structs, register indexes and the controller/datapath command struct.
// No dependencies.
package sobel_pkg;

  localparam int unsigned CfgIndexWidth = 1;
  localparam logic [CfgIndexWidth-1:0] RegImageWidth  = 1'b0;
  localparam logic [CfgIndexWidth-1:0] RegImageHeight = 1'b1;

  localparam logic [11:0] WidthReset  = 12'd640;
  localparam logic [12:0] HeightReset = 13'd480;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       flush;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] edge_red;
    logic [7:0] edge_green;
    logic [7:0] edge_blue;
    logic       frame_end;
  } pixel_out_t;

  // Per-item command from the controller to the datapath.
  typedef struct packed {
    logic pix_zero;    // drop pixel data
    logic emit_a;      // row-start result (right column outside)
    logic a_top_ok;
    logic a_bot_ok;
    logic a_left_ok;
    logic a_last;
    logic emit_b;      // in-row result
    logic b_top_ok;
    logic b_bot_ok;
    logic b_left_ok;
  } sob_cmd_t;

  // Sobel on one 8-bit channel; taps given row-major, already masked.
  function automatic logic [16:0] sob_mag_sq(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c, input logic [7:0] d,
                                              input logic [7:0] f, input logic [7:0] g,
                                              input logic [7:0] h, input logic [7:0] i);
    logic signed [11:0] gx;
    logic signed [11:0] gy;
    logic signed [23:0] gx2;
    logic signed [23:0] gy2;
    logic [21:0] s;
    gx = $signed({4'd0, c}) + $signed({3'd0, f, 1'b0}) + $signed({4'd0, i})
       - $signed({4'd0, a}) - $signed({3'd0, d, 1'b0}) - $signed({4'd0, g});
    gy = $signed({4'd0, g}) + $signed({3'd0, h, 1'b0}) + $signed({4'd0, i})
       - $signed({4'd0, a}) - $signed({3'd0, b, 1'b0}) - $signed({4'd0, c});
    gx2 = gx * gx;
    gy2 = gy * gy;
    s = gx2[21:0] + gy2[21:0];
    // saturate: anything at or above 65536 gives 65536, which the root makes 255
    sob_mag_sq = (s[21:16] != '0) ? 17'h10000 : {1'b0, s[15:0]};
  endfunction

endpackage

### design/sobel_ctrl.sv
// Controller for the Sobel block: input position, border masks, handshake.
// Depends on sobel_pkg.
module sobel_ctrl #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_flush,
  input  logic                  cfg_valid,
  input  logic [11:0]           cfg_width,
  input  logic [12:0]           cfg_height,
  input  logic                  busy,
  output logic                  issue,
  output sobel_pkg::sob_cmd_t   cmd,
  output logic [$clog2(MAX_WIDTH)-1:0] col_addr,
  output logic                  restart
);
  import sobel_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  typedef enum logic [0:0] {S_READY, S_WAIT} state_t;
  state_t state;

  logic [CW:0]  column_count;
  logic [12:0]  row_count;
  logic [CW:0]  w_eff;
  logic [12:0]  h_eff;
  logic [CW:0]  c;
  logic [CW:0]  c_inc;
  logic         done;

  // effective frame size
  always_comb begin
    logic [13:0] wx;
    wx = {2'b0, cfg_width};
    if (wx == '0) wx = 14'd1;
    if (wx > 14'(MAX_WIDTH)) wx = 14'(MAX_WIDTH);
    w_eff = (CW + 1)'(wx);
    h_eff = (cfg_height == '0) ? 13'd1 : cfg_height;
  end

  assign c = (column_count >= w_eff) ? '0 : column_count;
  assign col_addr = c[CW-1:0];
  assign in_ready = (state == S_READY) && !busy && !cfg_valid;
  assign issue    = in_valid && in_ready;
  assign restart  = cfg_valid;
  assign c_inc    = c + 1'b1;

  // border and emit decisions
  always_comb begin
    cmd.pix_zero  = in_flush || (row_count >= h_eff);
    cmd.emit_a    = (c == '0) && (row_count >= 13'd2);
    cmd.a_top_ok  = row_count >= 13'd3;
    cmd.a_bot_ok  = (row_count - 13'd1) < h_eff;
    cmd.a_left_ok = w_eff >= (CW + 1)'(2);
    cmd.a_last    = (row_count - 13'd2) == (h_eff - 13'd1);
    cmd.emit_b    = (c >= (CW + 1)'(1)) && (row_count >= 13'd1);
    cmd.b_top_ok  = row_count >= 13'd2;
    cmd.b_bot_ok  = row_count < h_eff;
    cmd.b_left_ok = c >= (CW + 1)'(2);
  end
  assign done = cmd.emit_a && cmd.a_last;

  // position and handshake state
  always_ff @(posedge clk) begin
    if (rst || cfg_valid) begin
      state        <= S_READY;
      column_count <= '0;
      row_count    <= '0;
    end else begin
      case (state)
        S_READY: begin
          if (issue) begin
            state <= S_WAIT;
            if (done) begin
              column_count <= '0;
              row_count    <= '0;
            end else if (c_inc >= w_eff) begin
              column_count <= '0;
              row_count    <= row_count + 13'd1;
            end else begin
              column_count <= c_inc;
            end
          end
        end
        S_WAIT: state <= S_READY;
        default: state <= S_READY;
      endcase
    end
  end
endmodule

### design/sobel_dp.sv
// Datapath for the Sobel block: line stores, window, magnitude, output queue.
// Depends on sobel_pkg.
module sobel_dp #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  issue,
  input  logic                  restart,
  input  sobel_pkg::sob_cmd_t   cmd,
  input  logic [$clog2(MAX_WIDTH)-1:0] col_addr,
  input  sobel_pkg::pixel_in_t  pix_in,
  output logic                  busy,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sobel_pkg::pixel_out_t out_word
);
  import sobel_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic [23:0] line_store_above [MAX_WIDTH];
  logic [23:0] line_store_middle [MAX_WIDTH];
  logic [23:0] rd_above, rd_middle;
  logic [23:0] win [3][3];       // [column][row]
  logic [23:0] pix_q;
  logic [CW-1:0] addr_q;
  sob_cmd_t    cmd_q;
  logic        stage1;           // window update + magnitude stage
  logic [1:0]  sq_valid;
  logic [16:0] sq [2][3];
  logic        sq_last [2];
  logic [16:0] rad [3];          // radicand being rooted
  logic [3:0]  bit_cnt;
  logic [7:0]  root [3];
  logic        sq_sel;           // which queue entry is being rooted
  logic        root_busy;
  logic        root_last;

  // line store reads, registered
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_above  <= line_store_above[col_addr];
      rd_middle <= line_store_middle[col_addr];
      addr_q    <= col_addr;
      pix_q     <= cmd.pix_zero ? 24'd0
                   : {pix_in.blue_in, pix_in.green_in, pix_in.red_in};
      cmd_q     <= cmd;
    end
    if (stage1) begin
      line_store_above[addr_q]  <= rd_middle;
      line_store_middle[addr_q] <= pix_q;
    end
  end

  // window update and squared magnitudes
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      stage1   <= 1'b0;
      sq_valid <= '0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) win[i][j] <= '0;
    end else begin
      stage1 <= issue;
      if (stage1) begin
        win[0] <= win[1];
        win[1] <= win[2];
        win[2] <= '{rd_above, rd_middle, pix_q};
        for (int k = 0; k < 3; k++) begin
          sq[0][k] <= sob_mag_sq(
            (cmd_q.a_top_ok && cmd_q.a_left_ok) ? win[1][0][8*k+:8] : 8'd0,
            cmd_q.a_top_ok ? win[2][0][8*k+:8] : 8'd0, 8'd0,
            cmd_q.a_left_ok ? win[1][1][8*k+:8] : 8'd0,
            8'd0,
            (cmd_q.a_bot_ok && cmd_q.a_left_ok) ? win[1][2][8*k+:8] : 8'd0,
            cmd_q.a_bot_ok ? win[2][2][8*k+:8] : 8'd0, 8'd0);
          sq[1][k] <= sob_mag_sq(
            (cmd_q.b_top_ok && cmd_q.b_left_ok) ? win[1][0][8*k+:8] : 8'd0,
            cmd_q.b_top_ok ? win[2][0][8*k+:8] : 8'd0,
            cmd_q.b_top_ok ? rd_above[8*k+:8] : 8'd0,
            cmd_q.b_left_ok ? win[1][1][8*k+:8] : 8'd0,
            rd_middle[8*k+:8],
            (cmd_q.b_bot_ok && cmd_q.b_left_ok) ? win[1][2][8*k+:8] : 8'd0,
            cmd_q.b_bot_ok ? win[2][2][8*k+:8] : 8'd0,
            cmd_q.b_bot_ok ? pix_q[8*k+:8] : 8'd0);
        end
        sq_last[0] <= cmd_q.a_last;
        sq_last[1] <= 1'b0;
        sq_valid   <= {cmd_q.emit_b, cmd_q.emit_a};
      end else if (!root_busy && !out_valid && sq_valid != '0) begin
        sq_valid[sq_sel] <= 1'b0;
      end
    end
  end

  assign sq_sel = sq_valid[0] ? 1'b0 : 1'b1;

  // bit-serial integer square root, one bit per cycle for all three channels
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      root_busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (!root_busy && !out_valid && !stage1 && sq_valid != '0) begin
        root_busy <= 1'b1;
        bit_cnt   <= 4'd7;
        root_last <= sq_last[sq_sel];
        for (int k = 0; k < 3; k++) begin
          root[k] <= 8'd0;
          rad[k]  <= sq[sq_sel][k];
        end
      end else if (root_busy) begin
        for (int k = 0; k < 3; k++) begin
          logic [7:0] t;
          t = root[k] | (8'd1 << bit_cnt[2:0]);
          if (rad[k][16] || ({1'b0, 16'(t) * 16'(t)} <= rad[k])) root[k] <= t;
        end
        if (bit_cnt == 4'd0) begin
          root_busy <= 1'b0;
          out_valid <= 1'b1;
        end
        bit_cnt <= bit_cnt - 4'd1;
      end
    end
  end

  // result word; root and root_last hold while out_valid is up
  assign out_word = '{edge_red: root[0], edge_green: root[1], edge_blue: root[2],
                      frame_end: root_last};

  assign busy = stage1 || (sq_valid != '0) || root_busy;
endmodule

### design/sobel_rgb_edge_magnitude.sv
// Top level: RGB Sobel 3x3 gradient magnitude, clamped to 255, per channel.
// Sequential: one word at a time; a word is taken only once the last has left the
// magnitude stage and the 8-step bit-serial square root; at most one result per
// word. A held result stalls the next. Results lag input by one row plus one pixel.
// Synchronous active-high rst restores width 640 and height 480 and restarts the
// frame; line stores unset.
module sobel_rgb_edge_magnitude #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sobel_pkg::pixel_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sobel_pkg::pixel_out_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [sobel_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [12:0]           cfg_data
);
  import sobel_pkg::*;

  logic [11:0] image_width;
  logic [12:0] image_height;
  logic        busy, issue, restart;
  sob_cmd_t    cmd;
  logic [$clog2(MAX_WIDTH)-1:0] col_addr;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WidthReset;
      image_height <= HeightReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegImageWidth:  image_width  <= cfg_data[11:0];
        RegImageHeight: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  sobel_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_flush(in_data.flush),
    .cfg_valid, .cfg_width(image_width), .cfg_height(image_height),
    .busy, .issue, .cmd, .col_addr, .restart
  );

  sobel_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk, .rst, .issue, .restart, .cmd, .col_addr, .pix_in(in_data),
    .busy, .out_valid, .out_ready, .out_word(out_data)
  );
endmodule

### tb/sobel_rgb_edge_magnitude_test.sv
// Testbench for sobel_rgb_edge_magnitude: directed table, then random frames.
// Self-checking against an internal Sobel magnitude predictor.
// Depends on sobel_pkg and the sobel_rgb_edge_magnitude RTL.
`timescale 1ns / 100ps

module sobel_rgb_edge_magnitude_test;
  import sobel_pkg::*;

  localparam int MaxW       = 2048;
  localparam int IdleLimit  = 20000;
  localparam int SettleCyc  = 60;
  localparam int NumRandom  = 1050;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic cfg_valid, cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [12:0] cfg_data;
  pixel_in_t  in_data;
  pixel_out_t out_data;

  sobel_rgb_edge_magnitude u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor state ----------------
  logic [11:0] width_reg;
  logic [12:0] height_reg;
  logic [23:0] row_above [MaxW];
  logic [23:0] row_middle[MaxW];
  logic [23:0] win [3][3];   // [column left..right][row top..bottom]
  logic [23:0] grid[3][3];   // [row][column], masked taps
  int col_pos, row_pos;

  pixel_out_t edge_q[$];
  int errors, words_in, words_out, frames_done;
  bit hold_done;

  function automatic int eff_w();
    int w;
    w = int'(width_reg);
    if (w == 0) w = 1;
    if (w > MaxW) w = MaxW;
    return w;
  endfunction

  function automatic int eff_h();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  function automatic void restart_frame();
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic void apply_reg(logic [CfgIndexWidth-1:0] idx, logic [12:0] val);
    if (idx == RegImageWidth) width_reg = val[11:0];
    else height_reg = val;
    restart_frame();
  endfunction

  function automatic int clamp_root(int gx, int gy);
    int s, root, t;
    s = gx * gx + gy * gy;
    if (s >= 65536) return 255;
    root = 0;
    for (int b = 128; b != 0; b = b >> 1) begin
      t = root | b;
      if (t * t <= s) root = t;
    end
    return root;
  endfunction

  // Load masked taps from window columns lc/mc/rc (-1 = outside image).
  function automatic void load_grid(int lc, int mc, int rc, bit top_ok, bit bot_ok,
                                    bit left_ok);
    bit rok;
    for (int r = 0; r < 3; r++) begin
      rok = (r == 0) ? top_ok : ((r == 2) ? bot_ok : 1'b1);
      grid[r][0] = (rok && left_ok && lc >= 0) ? win[lc][r] : '0;
      grid[r][1] = (rok && mc >= 0) ? win[mc][r] : '0;
      grid[r][2] = (rok && rc >= 0) ? win[rc][r] : '0;
    end
  endfunction

  function automatic pixel_out_t grid_edges(bit last);
    pixel_out_t o;
    int a, b, c, d, f, g, h, i, gx, gy, m[3];
    for (int k = 0; k < 3; k++) begin
      a = grid[0][0][8*k +: 8]; b = grid[0][1][8*k +: 8]; c = grid[0][2][8*k +: 8];
      d = grid[1][0][8*k +: 8]; f = grid[1][2][8*k +: 8];
      g = grid[2][0][8*k +: 8]; h = grid[2][1][8*k +: 8]; i = grid[2][2][8*k +: 8];
      gx = (c + 2 * f + i) - (a + 2 * d + g);
      gy = (g + 2 * h + i) - (a + 2 * b + c);
      m[k] = clamp_root(gx, gy);
    end
    o.edge_red   = m[0][7:0];
    o.edge_green = m[1][7:0];
    o.edge_blue  = m[2][7:0];
    o.frame_end  = last;
    return o;
  endfunction

  // Advance the raster position by one word; returns 1 with a result if one is due.
  function automatic bit sobel_step(pixel_in_t px, output pixel_out_t res);
    int w, h, r, c;
    logic [23:0] pix;
    logic [23:0] ncol[3];
    bit have, done;
    w = eff_w(); h = eff_h();
    r = row_pos; c = col_pos;
    have = 1'b0; done = 1'b0; res = '0;
    if (c >= w) c = 0;
    pix = (px.flush || r >= h) ? 24'd0 : {px.blue_in, px.green_in, px.red_in};
    ncol[0] = row_above[c];
    ncol[1] = row_middle[c];
    ncol[2] = pix;
    // row start: last pixel of the row two back
    if (c == 0 && r >= 2) begin
      load_grid(1, 2, -1, r >= 3, (r - 1) < h, w >= 2);
      done = (r - 2) == (h - 1);
      res = grid_edges(done);
      have = 1'b1;
    end
    for (int j = 0; j < 3; j++) begin
      win[0][j] = win[1][j];
      win[1][j] = win[2][j];
      win[2][j] = ncol[j];
    end
    row_above[c]  = ncol[1];
    row_middle[c] = pix;
    // inside a row
    if (c >= 1 && r >= 1) begin
      load_grid(0, 1, 2, r >= 2, r < h, c >= 2);
      res = grid_edges(1'b0);
      have = 1'b1;
    end
    if (done) begin
      row_pos = 0; col_pos = 0;
    end else begin
      c++;
      if (c >= w) begin
        c = 0; r++;
      end
      col_pos = c; row_pos = r;
    end
    return have;
  endfunction

  // ---------------- sender ----------------
  int burst_left, gap_len;

  task automatic push_word(pixel_in_t px, bit has_fixed, pixel_out_t fixed);
    pixel_out_t res;
    if (burst_left == 0) begin
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap_len > 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    words_in++;
    if (sobel_step(px, res)) edge_q.push_back(has_fixed ? fixed : res);
  endtask

  function automatic pixel_in_t rand_pixel(bit fl);
    pixel_in_t px;
    px.red_in   = $urandom_range(0, 255);
    px.green_in = $urandom_range(0, 255);
    px.blue_in  = $urandom_range(0, 255);
    px.flush    = fl;
    return px;
  endfunction

  // Stop offering, wait for all results, then let the block settle.
  task automatic drain_all();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (edge_q.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [12:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
    @(posedge clk);
  endtask

  // ---------------- receiver: stall pattern and long hold ----------------
  initial begin
    int mode;
    mode = 0;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!hold_done && words_out >= 300) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    pixel_out_t exp_w;
    if (!rst && out_valid && out_ready) begin
      words_out++;
      if (edge_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_data);
        errors++;
      end else begin
        exp_w = edge_q.pop_front();
        if (exp_w.frame_end) frames_done++;
        if (out_data.edge_red !== exp_w.edge_red)
          $display("%0t: edge_red expected %0d actual %0d", $time, exp_w.edge_red,
                   out_data.edge_red);
        if (out_data.edge_green !== exp_w.edge_green)
          $display("%0t: edge_green expected %0d actual %0d", $time, exp_w.edge_green,
                   out_data.edge_green);
        if (out_data.edge_blue !== exp_w.edge_blue)
          $display("%0t: edge_blue expected %0d actual %0d", $time, exp_w.edge_blue,
                   out_data.edge_blue);
        if (out_data.frame_end !== exp_w.frame_end)
          $display("%0t: frame_end expected %0d actual %0d", $time, exp_w.frame_end,
                   out_data.frame_end);
        if (out_data !== exp_w) errors++;
      end
    end
  end

  // ---------------- watchdog ----------------
  int idle_cyc;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= IdleLimit) begin
      $display("sobel_rgb_edge_magnitude_test NOT OK");
      $finish;
    end
  end

  // ---------------- directed table ----------------
  typedef struct {
    bit          is_cfg;
    logic [CfgIndexWidth-1:0] idx;
    logic [12:0] val;
    pixel_in_t   px;
    bit          has_fixed;
    pixel_out_t  fixed;
  } step_row_t;

  step_row_t plan[$];

  function automatic void add_cfg(logic [CfgIndexWidth-1:0] idx, logic [12:0] val);
    step_row_t s;
    s = '{1'b1, idx, val, '0, 1'b0, '0};
    plan.push_back(s);
  endfunction

  function automatic void add_px(logic [7:0] rd, logic [7:0] gr, logic [7:0] bl, bit fl,
                                 bit hf = 1'b0, pixel_out_t fx = '0);
    step_row_t s;
    s = '{1'b0, RegImageWidth, 13'd0, '{rd, gr, bl, fl}, hf, fx};
    plan.push_back(s);
  endfunction

  function automatic void build_plan();
    // 1x1 frame: centre tap alone gives zero, and that word ends the frame
    add_cfg(RegImageWidth, 13'd1);
    add_cfg(RegImageHeight, 13'd1);
    add_px(8'hff, 8'hff, 8'hff, 1'b0);
    add_px(8'h00, 8'h00, 8'h00, 1'b1);
    add_px(8'h00, 8'h00, 8'h00, 1'b1, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1});
    // 3x2 frame: extremes, a flush inside the frame, pixels past the last row
    add_cfg(RegImageWidth, 13'd3);
    add_cfg(RegImageHeight, 13'd2);
    add_px(8'hff, 8'h00, 8'hff, 1'b0);
    add_px(8'h00, 8'hff, 8'h00, 1'b0);
    add_px(8'hff, 8'hff, 8'hff, 1'b0);
    add_px(8'h55, 8'haa, 8'h0f, 1'b1);
    add_px(8'h00, 8'h00, 8'h00, 1'b0);
    add_px(8'hff, 8'h80, 8'h01, 1'b0);
    add_px(8'hff, 8'hff, 8'hff, 1'b0);
    add_px(8'hff, 8'hff, 8'hff, 1'b0);
    add_px(8'h00, 8'h00, 8'h00, 1'b1);
    add_px(8'h00, 8'h00, 8'h00, 1'b1);
    // new frame after frame end, cut short by the next write
    add_px(8'hff, 8'hff, 8'hff, 1'b0);
    add_px(8'h12, 8'h34, 8'h56, 1'b0);
    // zero width and height act as 1
    add_cfg(RegImageWidth, 13'd0);
    add_cfg(RegImageHeight, 13'd0);
    add_px(8'h80, 8'h7f, 8'hc3, 1'b0);
    add_px(8'h00, 8'h00, 8'h00, 1'b1);
    add_px(8'h00, 8'h00, 8'h00, 1'b1, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1});
    // oversize width saturates, largest height
    add_cfg(RegImageWidth, 13'd4095);
    add_cfg(RegImageHeight, 13'd8191);
    add_px(8'hff, 8'h00, 8'hff, 1'b0);
    add_px(8'h00, 8'hff, 8'h00, 1'b0);
    add_px(8'hff, 8'hff, 8'h00, 1'b0);
  endfunction

  // One frame with random content; optionally cut short as noise.
  task automatic random_frame(bit cut_short);
    int w, h, n, lim;
    w = eff_w(); h = eff_h();
    lim = (w * h < 200) ? w * h : 200;
    n = cut_short ? $urandom_range(1, lim) : w * h;
    for (int k = 0; k < n; k++)
      push_word(rand_pixel($urandom_range(0, 9) == 0), 1'b0, '0);
    if (!cut_short)
      for (int k = 0; k <= w; k++)
        push_word(rand_pixel($urandom_range(0, 19) != 0), 1'b0, '0);
  endtask

  function automatic logic [12:0] pick_width();
    case ($urandom_range(0, 9))
      0: return 13'd0;
      1: return 13'($urandom_range(9, 40));
      2: return 13'(4096 + $urandom_range(1, 9));   // upper bit dropped by the register
      default: return 13'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [12:0] pick_height();
    case ($urandom_range(0, 9))
      0: return 13'd0;
      1: return 13'(8192 - $urandom_range(1, 4));
      default: return 13'($urandom_range(1, 6));
    endcase
  endfunction

  // ---------------- main sequence ----------------
  initial begin
    errors = 0; words_in = 0; words_out = 0; frames_done = 0;
    hold_done = 1'b0; burst_left = 0;
    width_reg = WidthReset; height_reg = HeightReset;
    for (int i = 0; i < MaxW; i++) begin
      row_above[i] = '0; row_middle[i] = '0;
    end
    restart_frame();
    rst <= 1'b1;
    in_valid <= 1'b0; in_data <= '0;
    cfg_valid <= 1'b0; cfg_index <= RegImageWidth; cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    build_plan();
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_all();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        push_word(plan[i].px, plan[i].has_fixed, plan[i].fixed);
      end
    end

    // random frames, mostly well formed; a pause for full drain between settings
    while (words_in < NumRandom) begin
      drain_all();
      if ($urandom_range(0, 1)) begin
        write_reg(RegImageWidth, pick_width());
        write_reg(RegImageHeight, pick_height());
      end else begin
        write_reg(RegImageHeight, pick_height());
        write_reg(RegImageWidth, pick_width());
      end
      if (eff_h() > 50 || eff_w() > 8) begin
        random_frame(1'b1);
      end else begin
        repeat ($urandom_range(1, 3)) random_frame($urandom_range(0, 7) == 0);
      end
    end

    drain_all();
    $display("Covered %0d input words, %0d result words, %0d complete frames.",
             words_in, words_out, frames_done);
    if (errors == 0) begin
      $display("sobel_rgb_edge_magnitude_test OK");
    end else begin
      $display("sobel_rgb_edge_magnitude_test NOT OK");
    end
    $finish;
  end

endmodule
